/* sv/arb_pkg.sv */
// ----------------------------------------------------------------------------
// Aggregating ring buffer package
// Operation, status, merge-mode and register codes, state encoding.
// ----------------------------------------------------------------------------
package arb_pkg;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_GET    = 2'd1,
      OP_SET    = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_POS  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_BAD_MARK = 2'd3
   } status_type;

   localparam logic [2:0] AGG_LAST = 3'd0;
   localparam logic [2:0] AGG_MAX  = 3'd1;
   localparam logic [2:0] AGG_MIN  = 3'd2;
   localparam logic [2:0] AGG_AVG  = 3'd3;
   localparam logic [2:0] AGG_SUM  = 3'd4;

   localparam logic [1:0] REG_AGG_MODE  = 2'd0;
   localparam logic [1:0] REG_RING_SIZE = 2'd1;
   localparam logic [1:0] REG_STRONG    = 2'd2;

   localparam logic [3:0] MARK_EMPTY = 4'd15;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR,
      S_READ,
      S_EVAL,
      S_DIV,
      S_WRITE,
      S_DESC_OLD,
      S_DESC_NEW,
      S_OUT
   } state_type;

endpackage

/* sv/arb_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
module arb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

/* sv/aggregating_ring_buffer.sv */
// ----------------------------------------------------------------------------
// Aggregating ring buffer
// Slot ring addressed by age with push/get/set/update and running merges.
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// req      in   req_tvalid/req_tready     req_tdata: mode,position,is_marker,
//                                                    marker,value
// rsp      out  rsp_tvalid/rsp_tready     rsp_tdata: status,old/new fields
// csr      in   csr_valid/csr_ready       csr_index, csr_data
//
// One request at a time; an average-mode update also runs the bit-serial
// divider for mean/count. After reset a clearing pass empties the slots;
// req_tready stays low meanwhile. The response register holds while
// rsp_tready is low; the next request is taken as soon as the response
// is out.
// ----------------------------------------------------------------------------
module aggregating_ring_buffer #(
   parameter int ELEM_BITS = 28,
   parameter int DEPTH     = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], position[12:2], is_marker[13], marker[17:14], value[49:18]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], old_is_marker[2], old_marker[6:3], old_value[34:7],
   // new_is_marker[35], new_marker[39:36], new_value[67:40]
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW = ELEM_BITS + 4;
   localparam int MW = ELEM_BITS + FRAC_BITS;
   localparam int DCW = $clog2(MW + 1);
   localparam logic [ELEM_BITS-1:0] ELEM_MAX = {ELEM_BITS{1'b1}};

   // registers
   logic [2:0]  agg_mode_ff;
   logic [10:0] ring_size_ff;
   logic [13:0] strong_ff;
   logic [10:0] head_ff, head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         agg_mode_ff  <= arb_pkg::AGG_LAST;
         ring_size_ff <= 11'd1024;
         strong_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            arb_pkg::REG_AGG_MODE:  agg_mode_ff  <= csr_data[2:0];
            arb_pkg::REG_RING_SIZE: ring_size_ff <= csr_data[10:0];
            arb_pkg::REG_STRONG:    strong_ff    <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // effective size, 17 bits so DEPTH up to 65536 fits
   logic [16:0] size_c, depth_c;
   assign depth_c = 17'(DEPTH);
   always_comb begin
      size_c = (ring_size_ff == 11'd0) ? 17'd1 : 17'(ring_size_ff);
      if (size_c > depth_c) size_c = depth_c;
   end

   // request fields
   logic [1:0]  op_ff;
   logic [10:0] pos_ff;
   logic        mk_ff;
   logic [3:0]  mark_ff;
   logic [31:0] val_ff;

   arb_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;

   // memories
   logic          wr_en;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] ram_addr;
   logic [WW-1:0] word_wr, word_rd;
   logic [MW-1:0] mean_wr, mean_rd;

   // the clearing pass walks the slots directly
   assign ram_addr = (state_ff == arb_pkg::S_CLEAR) ? clr_ff : addr_ff;

   arb_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_words (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr),
      .wr_data(word_wr), .rd_data(word_rd));
   arb_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_means (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr),
      .wr_data(mean_wr), .rd_data(mean_rd));

   logic [WW-1:0]      word_ff, word_in;
   logic [MW-1:0]      mean_ff, mean_in;
   logic [1:0]         status_ff, status_in;
   logic [10:0]        newh_ff, newh_in;
   logic               err_ff, err_in;
   // divider: dividend in quo, remainder, divisor
   logic [MW-1:0]      quo_ff, quo_in;
   logic [MW:0]        rem_ff, rem_in;
   logic [ELEM_BITS:0] dvs_ff, dvs_in;
   logic               up_ff, up_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic [32:0]        old_ff, old_in, new_ff, new_in;
   logic               rv_ff, rv_in;

   // describe the current word/mean as {value, marker, is_marker}
   function automatic logic [32:0] describe(input logic [WW-1:0] w,
                                            input logic [MW-1:0] mn,
                                            input logic [2:0] am);
      logic [3:0]  m;
      logic [MW:0] r;
      logic [27:0] v;
      m = w[WW-1:ELEM_BITS];
      r = {1'b0, mn};
      if (FRAC_BITS > 0) r = r + ((MW+1)'(1) << (FRAC_BITS - 1));
      r = r >> FRAC_BITS;
      if (m != 4'd0) begin
         describe = {28'd0, m, 1'b1};
      end else begin
         v = (am == arb_pkg::AGG_AVG) ? 28'(r) : 28'(w[ELEM_BITS-1:0]);
         describe = {v, 4'd0, 1'b0};
      end
   endfunction

   function automatic logic is_strong(input logic [3:0] m, input logic [13:0] msk);
      is_strong = (m != 4'd0 && m != arb_pkg::MARK_EMPTY) ? msk[m - 4'd1] : 1'b0;
   endfunction

   logic [16:0] h1, idx17, pos17;
   logic        val_over;
   logic [3:0]  cur_m;
   logic [ELEM_BITS-1:0] cur_v;
   logic [ELEM_BITS:0]   sum_c;
   logic [MW-1:0]        tgt_c;
   logic [MW:0]          trial;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      addr_in   = addr_ff;
      word_in   = word_ff;
      mean_in   = mean_ff;
      status_in = status_ff;
      newh_in   = newh_ff;
      err_in    = err_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      up_in     = up_ff;
      dcnt_in   = dcnt_ff;
      old_in    = old_ff;
      new_in    = new_ff;
      rv_in     = rv_ff;
      head_in   = head_ff;
      wr_en     = 1'b0;
      word_wr   = word_ff;
      mean_wr   = mean_ff;
      req_tready = 1'b0;

      h1    = 17'(head_ff) + 17'd1;
      pos17 = 17'(pos_ff);
      idx17 = '0;
      val_over = (val_ff > 32'(ELEM_MAX));
      cur_m = word_ff[WW-1:ELEM_BITS];
      cur_v = word_ff[ELEM_BITS-1:0];
      sum_c = {1'b0, cur_v} + (ELEM_BITS+1)'(val_ff);
      tgt_c = MW'(val_ff[ELEM_BITS-1:0]) << FRAC_BITS;
      trial = {rem_ff[MW-1:0], quo_ff[MW-1]} - (MW+1)'(dvs_ff);

      case (state_ff)
         arb_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            word_wr = '1;
            mean_wr = '0;
            if (32'(clr_ff) == DEPTH - 1) state_in = arb_pkg::S_IDLE;
            clr_in  = clr_ff + AW'(1);
         end
         arb_pkg::S_IDLE: begin
            req_tready = !rv_ff;
            if (req_tvalid && !rv_ff) state_in = arb_pkg::S_ADDR;
         end
         arb_pkg::S_ADDR: begin
            err_in    = 1'b0;
            status_in = arb_pkg::ST_OK;
            if (op_ff == arb_pkg::OP_PUSH) begin
               if (h1 >= size_c + 17'd1) h1 = 17'd1;
               newh_in = 11'(h1);
               idx17 = h1 - 17'd1;
               state_in = arb_pkg::S_READ;
            end else if (pos_ff == 11'd0 || pos17 > size_c) begin
               status_in = arb_pkg::ST_BAD_POS;
               old_in = '0;
               new_in = '0;
               state_in = arb_pkg::S_OUT;
            end else begin
               idx17 = (pos17 > 17'(head_ff)) ? size_c + 17'(head_ff) - pos17
                                              : 17'(head_ff) - pos17;
               state_in = arb_pkg::S_READ;
            end
            if (idx17 >= depth_c) idx17 = idx17 - depth_c;
            addr_in = AW'(idx17);
         end
         arb_pkg::S_READ: state_in = arb_pkg::S_EVAL;
         arb_pkg::S_EVAL: begin
            word_in  = word_rd;
            mean_in  = mean_rd;
            old_in   = describe(word_rd, mean_rd, agg_mode_ff);
            state_in = arb_pkg::S_DESC_NEW;
            cur_m = word_rd[WW-1:ELEM_BITS];
            cur_v = word_rd[ELEM_BITS-1:0];
            sum_c = {1'b0, cur_v} + (ELEM_BITS+1)'(val_ff);
            if (op_ff == arb_pkg::OP_GET) begin
               state_in = arb_pkg::S_DESC_NEW;
            end else if (mk_ff && mark_ff == 4'd0) begin
               status_in = arb_pkg::ST_BAD_MARK;
            end else if (!mk_ff && val_over) begin
               status_in = arb_pkg::ST_OVERFLOW;
            end else if (op_ff == arb_pkg::OP_PUSH || op_ff == arb_pkg::OP_SET ||
                         (mk_ff && (cur_m == arb_pkg::MARK_EMPTY ||
                                    is_strong(mark_ff, strong_ff))) ||
                         (!mk_ff && cur_m != 4'd0 && !is_strong(cur_m, strong_ff))) begin
               // plain store
               if (mk_ff) begin
                  word_in = {mark_ff, ELEM_BITS'(0)};
                  if (agg_mode_ff == arb_pkg::AGG_AVG) mean_in = '0;
               end else if (agg_mode_ff == arb_pkg::AGG_AVG) begin
                  word_in = WW'(1);
                  mean_in = tgt_c;
               end else begin
                  word_in = WW'(val_ff[ELEM_BITS-1:0]);
               end
               state_in = arb_pkg::S_WRITE;
            end else if (!mk_ff && cur_m == 4'd0) begin
               case (agg_mode_ff)
                  arb_pkg::AGG_AVG: begin
                     if (cur_v == ELEM_MAX) begin
                        status_in = arb_pkg::ST_OVERFLOW;
                     end else begin
                        word_in = WW'(cur_v) + WW'(1);
                        up_in   = (tgt_c >= mean_rd);
                        quo_in  = (tgt_c >= mean_rd) ? tgt_c - mean_rd
                                                     : mean_rd - tgt_c;
                        rem_in  = '0;
                        dvs_in  = {1'b0, cur_v} + (ELEM_BITS+1)'(1);
                        dcnt_in = DCW'(MW);
                        state_in = arb_pkg::S_DIV;
                     end
                  end
                  arb_pkg::AGG_LAST: begin
                     word_in = WW'(val_ff[ELEM_BITS-1:0]);
                     state_in = arb_pkg::S_WRITE;
                  end
                  arb_pkg::AGG_MAX: begin
                     if (val_ff[ELEM_BITS-1:0] > cur_v)
                        word_in = WW'(val_ff[ELEM_BITS-1:0]);
                     state_in = arb_pkg::S_WRITE;
                  end
                  arb_pkg::AGG_MIN: begin
                     if (val_ff[ELEM_BITS-1:0] < cur_v)
                        word_in = WW'(val_ff[ELEM_BITS-1:0]);
                     state_in = arb_pkg::S_WRITE;
                  end
                  arb_pkg::AGG_SUM: begin
                     if (sum_c[ELEM_BITS]) status_in = arb_pkg::ST_OVERFLOW;
                     else begin
                        word_in = WW'(sum_c[ELEM_BITS-1:0]);
                        state_in = arb_pkg::S_WRITE;
                     end
                  end
                  default: ;
               endcase
            end
            err_in = (status_in != arb_pkg::ST_OK);
         end
         arb_pkg::S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (!trial[MW]) begin
               rem_in = {1'b0, trial[MW-1:0]};
               quo_in = {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = (MW+1)'({rem_ff[MW-1:0], quo_ff[MW-1]});
               quo_in = {quo_ff[MW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               // move the mean toward the target by the quotient
               mean_in  = up_ff ? mean_ff + quo_in : mean_ff - quo_in;
               state_in = arb_pkg::S_WRITE;
            end
         end
         arb_pkg::S_WRITE: begin
            wr_en = 1'b1;
            if (op_ff == arb_pkg::OP_PUSH) head_in = newh_ff;
            state_in = arb_pkg::S_DESC_NEW;
         end
         arb_pkg::S_DESC_NEW: begin
            new_in   = describe(word_ff, mean_ff, agg_mode_ff);
            state_in = arb_pkg::S_OUT;
         end
         arb_pkg::S_OUT: begin
            rv_in    = 1'b1;
            state_in = arb_pkg::S_IDLE;
         end
         default: state_in = arb_pkg::S_IDLE;
      endcase
      if (rv_ff && rsp_tready) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arb_pkg::S_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      word_ff   <= word_in;
      mean_ff   <= mean_in;
      status_ff <= status_in;
      newh_ff   <= newh_in;
      err_ff    <= err_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      up_ff     <= up_in;
      dcnt_ff   <= dcnt_in;
      old_ff    <= old_in;
      new_ff    <= new_in;
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tdata[1:0];
         pos_ff  <= req_tdata[12:2];
         mk_ff   <= req_tdata[13];
         mark_ff <= req_tdata[17:14];
         val_ff  <= req_tdata[49:18];
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {4'd0, new_ff, old_ff, status_ff};

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == arb_pkg::S_IDLE)
      else $error("ready outside idle");
   a_no_write_on_err: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arb_pkg::S_WRITE) |-> !err_ff)
      else $error("write after error");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_badpos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == arb_pkg::ST_BAD_POS |-> rsp_tdata[67:2] == '0)
      else $error("bad position payload");
`endif

endmodule

/* tb/sv/aggregating_ring_buffer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aggregating ring buffer testbench
// Drives push/get/set/update requests with random gaps on both channels. A
// model of the slot ring computes every response. The ring is reconfigured
// between phases: merge mode, ring size and strong-marker mask.
// ----------------------------------------------------------------------------
module aggregating_ring_buffer_test;

   localparam int EB = 28;
   localparam int NSLOT = 1024;
   localparam int FB = 16;
   localparam logic [63:0] ELEM_MAX = (64'd1 << EB) - 1;
   localparam logic [63:0] MEAN_MAX = (64'd1 << (EB + FB)) - 1;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [31:0]         value;
      logic [3:0]          marker;
      logic                is_marker;
      logic [10:0]         position;
      arb_pkg::op_type     mode;
   } request_type;

   typedef struct packed {
      logic [27:0]         new_value;
      logic [3:0]          new_marker;
      logic                new_is_marker;
      logic [27:0]         old_value;
      logic [3:0]          old_marker;
      logic                old_is_marker;
      arb_pkg::status_type status;
   } response_type;

   typedef struct {
      request_type  req;
      logic         has_fixed;
      response_type fixed;
   } vector_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [13:0] csr_data = '0;

   aggregating_ring_buffer i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // ring model
   logic [63:0] word_q[NSLOT];
   logic [63:0] mean_q[NSLOT];
   int unsigned head_q;
   logic [2:0]  agg_q;
   logic [10:0] size_q;
   logic [13:0] strong_q;

   response_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic int unsigned live_size();
      if (size_q == 0) return 1;
      if (size_q > NSLOT) return NSLOT;
      return size_q;
   endfunction

   function automatic logic [3:0] mark_of(logic [63:0] w);
      return w[EB +: 4];
   endfunction

   function automatic bit strong_mark(logic [3:0] m);
      if (m == 0 || m == arb_pkg::MARK_EMPTY) return 0;
      return strong_q[m - 1];
   endfunction

   function automatic void show_slot(int unsigned idx, output logic mk, output logic [3:0] m,
                                     output logic [27:0] v);
      logic [63:0] mn;
      m = mark_of(word_q[idx]);
      mk = (m != 0);
      v = '0;
      if (mk) return;
      if (agg_q == arb_pkg::AGG_AVG) begin
         mn = mean_q[idx] & MEAN_MAX;
         v = 28'((mn + (64'd1 << (FB - 1))) >> FB);
      end else begin
         v = 28'(word_q[idx] & ELEM_MAX);
      end
   endfunction

   function automatic void store_slot(int unsigned idx, logic mk, logic [3:0] m,
                                      logic [63:0] val);
      if (mk) begin
         word_q[idx] = 64'(m) << EB;
         if (agg_q == arb_pkg::AGG_AVG) mean_q[idx] = 0;
      end else if (agg_q == arb_pkg::AGG_AVG) begin
         word_q[idx] = 1;
         mean_q[idx] = (val << FB) & MEAN_MAX;
      end else begin
         word_q[idx] = val;
      end
   endfunction

   function automatic arb_pkg::status_type merge_value(int unsigned idx, logic [63:0] val);
      logic [3:0]  m;
      logic [63:0] cur, cnt, mn, tgt;
      m = mark_of(word_q[idx]);
      cur = word_q[idx] & ELEM_MAX;
      if (strong_mark(m)) return arb_pkg::ST_OK;
      if (agg_q == arb_pkg::AGG_AVG) begin
         if (m != 0) begin
            store_slot(idx, 0, 0, val);
            return arb_pkg::ST_OK;
         end
         if (cur == ELEM_MAX) return arb_pkg::ST_OVERFLOW;
         cnt = cur + 1;
         mn = mean_q[idx] & MEAN_MAX;
         tgt = val << FB;
         if (tgt >= mn) mn = mn + (tgt - mn) / cnt;
         else mn = mn - (mn - tgt) / cnt;
         word_q[idx] = cnt;
         mean_q[idx] = mn & MEAN_MAX;
         return arb_pkg::ST_OK;
      end
      if (m != 0) begin
         word_q[idx] = val;
         return arb_pkg::ST_OK;
      end
      case (agg_q)
         arb_pkg::AGG_LAST: word_q[idx] = val;
         arb_pkg::AGG_MAX: if (val > cur) word_q[idx] = val;
         arb_pkg::AGG_MIN: if (val < cur) word_q[idx] = val;
         arb_pkg::AGG_SUM: begin
            if (cur + val > ELEM_MAX) return arb_pkg::ST_OVERFLOW;
            word_q[idx] = cur + val;
         end
         default: ;
      endcase
      return arb_pkg::ST_OK;
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type o;
      int unsigned h, idx, pos;
      bit bad;
      logic [63:0] val;
      o = '0;
      val = 64'(r.value);
      bad = 0;
      if (r.mode == arb_pkg::OP_PUSH) begin
         h = head_q + 1;
         if (h >= live_size() + 1) h = 1;
         idx = (h - 1) % NSLOT;
         if (r.is_marker && r.marker == 0) begin
            o.status = arb_pkg::ST_BAD_MARK;
            bad = 1;
         end else if (!r.is_marker && val > ELEM_MAX) begin
            o.status = arb_pkg::ST_OVERFLOW;
            bad = 1;
         end
         show_slot(idx, o.old_is_marker, o.old_marker, o.old_value);
         if (!bad) begin
            head_q = h;
            store_slot(idx, r.is_marker, r.marker, val);
         end
         show_slot(idx, o.new_is_marker, o.new_marker, o.new_value);
         return o;
      end
      pos = r.position;
      if (pos == 0 || pos > live_size()) begin
         o.status = arb_pkg::ST_BAD_POS;
         return o;
      end
      idx = ((pos > head_q) ? (live_size() + head_q - pos) : (head_q - pos)) % NSLOT;
      show_slot(idx, o.old_is_marker, o.old_marker, o.old_value);
      o.status = arb_pkg::ST_OK;
      if (r.mode != arb_pkg::OP_GET) begin
         if (r.is_marker && r.marker == 0) o.status = arb_pkg::ST_BAD_MARK;
         else if (!r.is_marker && val > ELEM_MAX) o.status = arb_pkg::ST_OVERFLOW;
         else if (r.mode == arb_pkg::OP_SET) store_slot(idx, r.is_marker, r.marker, val);
         else if (r.is_marker) begin
            if (mark_of(word_q[idx]) == arb_pkg::MARK_EMPTY || strong_mark(r.marker))
               store_slot(idx, 1, r.marker, 0);
         end else o.status = merge_value(idx, val);
      end
      show_slot(idx, o.new_is_marker, o.new_marker, o.new_value);
      return o;
   endfunction

   // starts and ends at a falling edge; valid drops only when a gap is drawn
   task automatic send_request(request_type r, bit has_fixed = 0, response_type fixed = '0);
      response_type e;
      int n;
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tdata <= 56'(r);
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      e = apply_request(r);
      if (has_fixed && e != fixed) begin
         $error("table row disagrees with model: exp %h model %h", fixed, e);
         errors++;
      end
      expected_q.push_back(has_fixed ? fixed : e);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      wait (expected_q.size() == 0);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [13:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         arb_pkg::REG_AGG_MODE: agg_q = data[2:0];
         arb_pkg::REG_RING_SIZE: size_q = data[10:0];
         arb_pkg::REG_STRONG: strong_q = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic request_type random_request(int unsigned sz);
      request_type r;
      int k;
      r.mode = arb_pkg::op_type'($urandom_range(0, 3));
      k = $urandom_range(0, 19);
      r.position = (k == 0) ? 11'($urandom) : (k == 1) ? 11'(sz + 1) :
                   (k == 2) ? 11'(sz) : 11'($urandom_range(1, sz));
      r.is_marker = ($urandom_range(0, 4) == 0);
      r.marker = ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      k = $urandom_range(0, 9);
      r.value = (k == 0) ? $urandom : (k == 1) ? 32'(ELEM_MAX - $urandom_range(0, 3)) :
                (k < 5) ? $urandom_range(0, 20) : 32'($urandom) & 32'(ELEM_MAX);
      return r;
   endfunction

   function automatic request_type mk_req(arb_pkg::op_type op, int pos, bit mk, int m,
                                          logic [31:0] v);
      request_type r;
      r.mode = op;
      r.position = 11'(pos);
      r.is_marker = mk;
      r.marker = 4'(m);
      r.value = v;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      response_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = response_type'(rsp_tdata[67:0]);
         if (expected_q.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            exp = expected_q.pop_front();
            if (got.status != exp.status) begin
               $error("status exp %0d got %0d", exp.status, got.status); errors++;
            end
            if (got.old_is_marker != exp.old_is_marker) begin
               $error("old_is_marker exp %0d got %0d", exp.old_is_marker,
                      got.old_is_marker); errors++;
            end
            if (got.old_marker != exp.old_marker) begin
               $error("old_marker exp %0d got %0d", exp.old_marker, got.old_marker);
               errors++;
            end
            if (got.old_value != exp.old_value) begin
               $error("old_value exp %0d got %0d", exp.old_value, got.old_value);
               errors++;
            end
            if (got.new_is_marker != exp.new_is_marker) begin
               $error("new_is_marker exp %0d got %0d", exp.new_is_marker,
                      got.new_is_marker); errors++;
            end
            if (got.new_marker != exp.new_marker) begin
               $error("new_marker exp %0d got %0d", exp.new_marker, got.new_marker);
               errors++;
            end
            if (got.new_value != exp.new_value) begin
               $error("new_value exp %0d got %0d", exp.new_value, got.new_value);
               errors++;
            end
         end
      end
   end

   // response-side stalls
   initial begin
      int n;
      forever begin
         @(negedge clock);
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // watchdog; the clearing pass after reset stays well inside the limit
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      vector_type tbl[$];
      response_type f;
      logic [2:0] modes[7] = '{arb_pkg::AGG_LAST, arb_pkg::AGG_MAX, arb_pkg::AGG_MIN,
                               arb_pkg::AGG_AVG, arb_pkg::AGG_SUM, 3'd7, arb_pkg::AGG_AVG};
      int unsigned sz;
      for (int i = 0; i < NSLOT; i++) begin
         word_q[i] = (64'd15 << EB) | ELEM_MAX;
         mean_q[i] = 0;
      end
      head_q = 0; agg_q = arb_pkg::AGG_LAST; size_q = 11'd1024; strong_q = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // read an empty slot straight after reset
      f = '0; f.status = arb_pkg::ST_OK; f.old_is_marker = 1;
      f.old_marker = arb_pkg::MARK_EMPTY;
      f.new_is_marker = 1; f.new_marker = arb_pkg::MARK_EMPTY;
      tbl.push_back('{mk_req(arb_pkg::OP_GET, 1024, 0, 0, 0), 1, f});
      f = '0; f.status = arb_pkg::ST_BAD_POS;
      tbl.push_back('{mk_req(arb_pkg::OP_GET, 0, 0, 0, 0), 1, f});
      tbl.push_back('{mk_req(arb_pkg::OP_SET, 1025, 0, 0, 0), 1, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 2047, 1, 3, 0), 1, f});
      // overflow on push: head stays, slot shown twice
      f = '0; f.status = arb_pkg::ST_OVERFLOW; f.old_is_marker = 1;
      f.old_marker = arb_pkg::MARK_EMPTY;
      f.new_is_marker = 1; f.new_marker = arb_pkg::MARK_EMPTY;
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 0, 0, 0, 32'h1000_0000), 1, f});
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 0, 0, 0, 32'hFFFF_FFFF), 1, f});
      f.status = arb_pkg::ST_BAD_MARK;
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 2047, 1, 0, 32'hFFFF_FFFF), 1, f});
      f = '0; f.old_is_marker = 1; f.old_marker = arb_pkg::MARK_EMPTY;
      f.new_value = 28'hFFF_FFFF;
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 5, 0, 15, 32'h0FFF_FFFF), 1, f});
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 0, 0, 0, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 0, 1, 14, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_PUSH, 0, 1, 1, 32'hFFFF_FFFF), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_GET, 4, 0, 0, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 1, 0, 0, 7), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 2, 1, 2, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 5, 1, 2, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 5, 1, 0, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_SET, 3, 1, 15, 0), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 3, 0, 0, 32'h1234_5678), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_UPDATE, 4, 0, 0, 1), 0, f});
      tbl.push_back('{mk_req(arb_pkg::OP_SET, 2, 0, 0, 32'h0ABC_DEF0), 0, f});
      foreach (tbl[i]) send_request(tbl[i].req, tbl[i].has_fixed, tbl[i].fixed);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 12; ph++) begin
         if (ph > 0) drain();
         write_reg(arb_pkg::REG_AGG_MODE, 14'(modes[ph % 7]));
         case (ph % 4)
            0: write_reg(arb_pkg::REG_RING_SIZE, 14'($urandom_range(1, 8)));
            1: write_reg(arb_pkg::REG_RING_SIZE, 14'd1);
            2: write_reg(arb_pkg::REG_RING_SIZE,
                         (ph == 6) ? 14'd1024 : 14'($urandom_range(1, 2047)));
            default: write_reg(arb_pkg::REG_RING_SIZE, (ph == 11) ? 14'd0 : 14'd3);
         endcase
         write_reg(arb_pkg::REG_STRONG,
                   (ph == 2) ? 14'h3FFF : (ph == 5) ? 14'h0 : 14'($urandom));
         sz = live_size();
         for (int i = 0; i < 150; i++) begin
            send_request(random_request(sz));
            if (ph == 4 && i == 75) drain();
         end
      end

      drain();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
sv/arb_pkg.sv
sv/arb_ram.sv
sv/aggregating_ring_buffer.sv
tb/sv/aggregating_ring_buffer_test.sv
